FILE: rtl/eatrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eatrm_pkg
// Shared types and constants of the Euler angle to rotation matrix block.
// ----------------------------------------------------------------------------
package eatrm_pkg;

  // Fixed point format of table entries and matrix elements (signed 4.12)
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned SIN_W   = 17;  // a negated sine may reach +32768
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned ELEM_N  = 9;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TIDX_W  = 12;
  localparam int unsigned T_W     = 20;  // low 32 bits of a product, shifted right by 12

  // Output queue depth, also the limit on matrices in flight
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CW    = 3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CALC = 1'b1
  } op_e;

  // Which angle a table read belongs to
  typedef enum logic [1:0] {
    SLOT_NONE = 2'd0,
    SLOT_X    = 2'd1,
    SLOT_Y    = 2'd2,
    SLOT_Z    = 2'd3
  } slot_e;

  // Read sequencer of a matrix word
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ_Y = 2'd1,
    ST_READ_Z = 2'd2
  } seq_state_e;

  // Sine and cosine of the three angles after lookup
  typedef struct packed {
    logic signed [SIN_W-1:0]  sx;
    logic signed [ELEM_W-1:0] cx;
    logic signed [SIN_W-1:0]  sy;
    logic signed [ELEM_W-1:0] cy;
    logic signed [SIN_W-1:0]  sz;
    logic signed [ELEM_W-1:0] cz;
  } trig_t;

  typedef logic [ELEM_N-1:0][ELEM_W-1:0] mat_t;

endpackage

`default_nettype wire

FILE: rtl/euler_angles_to_rotation_matrix_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top
// Three angles to a 3x3 rotation matrix in 4.12 fixed point, using a loaded
// sine/cosine table.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid_i/in_stall_o | op, table_index, table_word, angle_x/y/z
//  out     | out_valid_o/out_stall_i | element_0 .. element_8
//
//  A load word writes one table entry; a matrix word makes three table reads,
//  one per angle, through the single port of the sine/cosine memory, and the
//  input stalls until the last of them is issued.
//  The table is not cleared by reset; ANGLE_STEPS must be a power of two.
//  Up to OQ_DEPTH matrices may be in flight or queued; beyond that the input
//  stalls until the output side takes words.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top #(
  parameter int unsigned ANGLE_STEPS = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 op_i,
  input  wire logic [eatrm_pkg::TIDX_W-1:0]         table_index_i,
  input  wire logic [eatrm_pkg::WORD_W-1:0]         table_word_i,
  input  wire logic signed [eatrm_pkg::ANGLE_W-1:0] angle_x_i,
  input  wire logic signed [eatrm_pkg::ANGLE_W-1:0] angle_y_i,
  input  wire logic signed [eatrm_pkg::ANGLE_W-1:0] angle_z_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_0_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_1_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_2_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_3_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_4_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_5_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_6_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_7_o,
  output logic signed [eatrm_pkg::ELEM_W-1:0]       element_8_o
);

  localparam int unsigned AW = $clog2(ANGLE_STEPS);

  logic             credit_ok, calc_acc, trig_vld, res_vld, out_acc;
  eatrm_pkg::trig_t trig;
  eatrm_pkg::mat_t  res;

  eatrm_seq #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .AW          (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .table_index_i (table_index_i),
    .table_word_i  (table_word_i),
    .angle_x_i     (angle_x_i),
    .angle_y_i     (angle_y_i),
    .angle_z_i     (angle_z_i),
    .credit_ok_i   (credit_ok),
    .calc_acc_o    (calc_acc),
    .trig_vld_o    (trig_vld),
    .trig_o        (trig)
  );

  eatrm_mat u_mat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .trig_vld_i (trig_vld),
    .trig_i     (trig),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // Output queue; in-flight count keeps it from overflowing
  eatrm_pkg::mat_t                oq_q [eatrm_pkg::OQ_DEPTH];
  logic [eatrm_pkg::OQ_AW-1:0]    wptr_q, rptr_q;
  logic [eatrm_pkg::OQ_CW-1:0]    cnt_q, infl_q;

  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign credit_ok   = (infl_q < eatrm_pkg::OQ_CW'(eatrm_pkg::OQ_DEPTH));

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      oq_q[wptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      infl_q <= '0;
    end else begin
      if (res_vld) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (out_acc) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q  <= cnt_q + eatrm_pkg::OQ_CW'(res_vld) - eatrm_pkg::OQ_CW'(out_acc);
      infl_q <= infl_q + eatrm_pkg::OQ_CW'(calc_acc) - eatrm_pkg::OQ_CW'(out_acc);
    end
  end

  assign element_0_o = oq_q[rptr_q][0];
  assign element_1_o = oq_q[rptr_q][1];
  assign element_2_o = oq_q[rptr_q][2];
  assign element_3_o = oq_q[rptr_q][3];
  assign element_4_o = oq_q[rptr_q][4];
  assign element_5_o = oq_q[rptr_q][5];
  assign element_6_o = oq_q[rptr_q][6];
  assign element_7_o = oq_q[rptr_q][7];
  assign element_8_o = oq_q[rptr_q][8];

endmodule

`default_nettype wire

FILE: rtl/eatrm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eatrm_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module eatrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/eatrm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eatrm_seq
// Input side: takes words, writes table entries, issues the three table reads
// of a matrix word and turns the read data into signed sine and cosine.
// ----------------------------------------------------------------------------
module eatrm_seq #(
  parameter int unsigned ANGLE_STEPS = 4096,
  parameter int unsigned AW          = $clog2(ANGLE_STEPS)
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic                                    op_i,
  input  wire logic [eatrm_pkg::TIDX_W-1:0]            table_index_i,
  input  wire logic [eatrm_pkg::WORD_W-1:0]            table_word_i,
  input  wire logic signed [eatrm_pkg::ANGLE_W-1:0]    angle_x_i,
  input  wire logic signed [eatrm_pkg::ANGLE_W-1:0]    angle_y_i,
  input  wire logic signed [eatrm_pkg::ANGLE_W-1:0]    angle_z_i,
  input  wire logic                                    credit_ok_i,
  output logic                                         calc_acc_o,
  output logic                                         trig_vld_o,
  output eatrm_pkg::trig_t                             trig_o
);

  // Table index of an angle: magnitude modulo the table depth
  function automatic logic [AW-1:0] angle_idx(logic signed [eatrm_pkg::ANGLE_W-1:0] a);
    logic [eatrm_pkg::ANGLE_W:0] mag;
    mag = a[eatrm_pkg::ANGLE_W-1] ? (eatrm_pkg::ANGLE_W+1)'(-{a[eatrm_pkg::ANGLE_W-1], a})
                                  : {1'b0, a};
    return mag[AW-1:0];
  endfunction

  eatrm_pkg::seq_state_e                state_q, state_d;
  logic signed [eatrm_pkg::ANGLE_W-1:0] ay_q, az_q;
  logic                                 accept, calc_acc;
  logic                                 ram_en, ram_we;
  logic [AW-1:0]                        ram_addr;
  logic [AW+eatrm_pkg::TIDX_W-1:0]      tix_ext;
  logic [eatrm_pkg::WORD_W-1:0]         rdata;
  eatrm_pkg::slot_e                     slot_q, slot_d;
  logic                                 neg_q, neg_d;
  logic signed [eatrm_pkg::SIN_W-1:0]   sine;
  logic signed [eatrm_pkg::ELEM_W-1:0]  cosine;
  logic signed [eatrm_pkg::SIN_W-1:0]   sx_q, sy_q;
  logic signed [eatrm_pkg::ELEM_W-1:0]  cx_q, cy_q;
  eatrm_pkg::trig_t                     trig_q;
  logic                                 trig_vld_q;

  // One table access per cycle: a matrix word holds the port through its three reads; no credit also stalls
  assign in_stall_o = (state_q != eatrm_pkg::ST_IDLE) || !credit_ok_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign calc_acc   = accept && (op_i == eatrm_pkg::OP_CALC);
  assign calc_acc_o = calc_acc;

  assign tix_ext = {{AW{1'b0}}, table_index_i};

  // Port mux, read tagging and next state
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = angle_idx(angle_x_i);
    slot_d   = eatrm_pkg::SLOT_NONE;
    neg_d    = angle_x_i[eatrm_pkg::ANGLE_W-1];
    state_d  = state_q;
    unique case (state_q)
      eatrm_pkg::ST_READ_Y: begin
        ram_en   = 1'b1;
        ram_addr = angle_idx(ay_q);
        slot_d   = eatrm_pkg::SLOT_Y;
        neg_d    = ay_q[eatrm_pkg::ANGLE_W-1];
        state_d  = eatrm_pkg::ST_READ_Z;
      end
      eatrm_pkg::ST_READ_Z: begin
        ram_en   = 1'b1;
        ram_addr = angle_idx(az_q);
        slot_d   = eatrm_pkg::SLOT_Z;
        neg_d    = az_q[eatrm_pkg::ANGLE_W-1];
        state_d  = eatrm_pkg::ST_IDLE;
      end
      default: begin
        // idle: a load writes now, a matrix word reads angle x now
        if (accept) begin
          ram_en = 1'b1;
          if (op_i == eatrm_pkg::OP_LOAD) begin
            ram_we   = 1'b1;
            ram_addr = tix_ext[AW-1:0];
          end else begin
            slot_d  = eatrm_pkg::SLOT_X;
            state_d = eatrm_pkg::ST_READ_Y;
          end
        end
      end
    endcase
  end

  eatrm_ram #(
    .WIDTH (eatrm_pkg::WORD_W),
    .DEPTH (ANGLE_STEPS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (table_word_i),
    .rdata_o (rdata)
  );

  // Decode read data: sign-extend, negate sine for negative angles
  always_comb begin
    sine   = eatrm_pkg::SIN_W'($signed(rdata[eatrm_pkg::ELEM_W-1:0]));
    cosine = $signed(rdata[eatrm_pkg::WORD_W-1:eatrm_pkg::ELEM_W]);
    if (neg_q) begin
      sine = -sine;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= eatrm_pkg::ST_IDLE;
      slot_q     <= eatrm_pkg::SLOT_NONE;
      trig_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      trig_vld_q <= (slot_q == eatrm_pkg::SLOT_Z);
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    if (calc_acc) begin
      ay_q <= angle_y_i;
      az_q <= angle_z_i;
    end
    case (slot_q)
      eatrm_pkg::SLOT_X: begin
        sx_q <= sine;
        cx_q <= cosine;
      end
      eatrm_pkg::SLOT_Y: begin
        sy_q <= sine;
        cy_q <= cosine;
      end
      eatrm_pkg::SLOT_Z: begin
        trig_q <= '{sx: sx_q, cx: cx_q, sy: sy_q, cy: cy_q, sz: sine, cz: cosine};
      end
      default: begin
      end
    endcase
  end

  assign trig_vld_o = trig_vld_q;
  assign trig_o     = trig_q;

endmodule

`default_nettype wire

FILE: rtl/eatrm_mat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eatrm_mat
// Two multiply stages: first the direct products and the two cross terms,
// then the products of the cross terms and the final sums.
// ----------------------------------------------------------------------------
module eatrm_mat (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             trig_vld_i,
  input  wire eatrm_pkg::trig_t trig_i,
  output logic                  res_vld_o,
  output eatrm_pkg::mat_t       res_o
);

  localparam int unsigned PW = 2 * eatrm_pkg::SIN_W - 1;            // 33
  localparam int unsigned QW = eatrm_pkg::T_W + eatrm_pkg::SIN_W;   // 37
  localparam int unsigned LO = eatrm_pkg::FRAC_W;
  localparam int unsigned HI = eatrm_pkg::FRAC_W + eatrm_pkg::ELEM_W - 1;

  // Stage A products
  logic signed [eatrm_pkg::SIN_W-1:0] nsy;
  logic signed [PW-1:0] p_t, p_u, p_czcy, p_szcy, p_cysx, p_cycx;
  logic signed [PW-1:0] p_szcx, p_czcx, p_szsx, p_czsx;
  logic signed [PW-1:0] n_szcy, n_cysx;

  assign nsy    = -trig_i.sy;
  assign p_t    = trig_i.cz * nsy;
  assign p_u    = trig_i.sz * nsy;
  assign p_czcy = trig_i.cz * trig_i.cy;
  assign p_szcy = trig_i.sz * trig_i.cy;
  assign p_cysx = trig_i.cy * trig_i.sx;
  assign p_cycx = trig_i.cy * trig_i.cx;
  assign p_szcx = trig_i.sz * trig_i.cx;
  assign p_czcx = trig_i.cz * trig_i.cx;
  assign p_szsx = trig_i.sz * trig_i.sx;
  assign p_czsx = trig_i.cz * trig_i.sx;
  assign n_szcy = -p_szcy;
  assign n_cysx = -p_cysx;

  logic                                 a_vld_q;
  logic signed [eatrm_pkg::T_W-1:0]     t_q, u_q;
  logic signed [eatrm_pkg::SIN_W-1:0]   sx_q;
  logic signed [eatrm_pkg::ELEM_W-1:0]  cx_q;
  logic [eatrm_pkg::ELEM_W-1:0]         e0_q, e1_q, e2_q, e5_q, e8_q;
  logic [eatrm_pkg::ELEM_W-1:0]         p3_q, p4_q, p6_q, p7_q;

  always_ff @(posedge clk_i) begin
    t_q  <= p_t[eatrm_pkg::WORD_W-1:LO];
    u_q  <= p_u[eatrm_pkg::WORD_W-1:LO];
    sx_q <= trig_i.sx;
    cx_q <= trig_i.cx;
    e0_q <= p_czcy[HI:LO];
    e1_q <= n_szcy[HI:LO];
    e2_q <= trig_i.sy[eatrm_pkg::ELEM_W-1:0];
    e5_q <= n_cysx[HI:LO];
    e8_q <= p_cycx[HI:LO];
    p3_q <= p_szcx[HI:LO];
    p4_q <= p_czcx[HI:LO];
    p6_q <= p_szsx[HI:LO];
    p7_q <= p_czsx[HI:LO];
  end

  // Stage B: cross-term products, wrapped sums
  logic signed [QW-1:0] q_tsx, q_usx, q_tcx, q_ucx;

  assign q_tsx = t_q * sx_q;
  assign q_usx = u_q * sx_q;
  assign q_tcx = t_q * cx_q;
  assign q_ucx = u_q * cx_q;

  logic            res_vld_q;
  eatrm_pkg::mat_t res_q;

  always_ff @(posedge clk_i) begin
    res_q[0] <= e0_q;
    res_q[1] <= e1_q;
    res_q[2] <= e2_q;
    res_q[3] <= p3_q - q_tsx[HI:LO];
    res_q[4] <= p4_q + q_usx[HI:LO];
    res_q[5] <= e5_q;
    res_q[6] <= p6_q + q_tcx[HI:LO];
    res_q[7] <= p7_q - q_ucx[HI:LO];
    res_q[8] <= e8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= trig_vld_i;
      res_vld_q <= a_vld_q;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_euler_angles_to_rotation_matrix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_matrix_top
// Loads entries of the sine/cosine table and sends angle triples. Each matrix
// that comes back is checked element by element against a matrix worked out
// in the bench from its own copy of the table. Both sides pause at random,
// and once the output side holds off long enough for the input to stall.
// ----------------------------------------------------------------------------
module tb_euler_angles_to_rotation_matrix_top;

  localparam int unsigned ANGLE_STEPS  = 4096;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned HOLD_CYCLES  = 300;

  // Expected matrices, worked out from a private copy of the table
  class matrix_board;
    logic [31:0]     sine_cosine [ANGLE_STEPS];
    eatrm_pkg::mat_t pending_matrices [$];
    int unsigned     bad_count;
    int unsigned     shown;

    function logic [31:0] shr12(input logic [31:0] v);
      return {{12{v[31]}}, v[31:12]};
    endfunction

    // Sine (sign follows the angle) and cosine, sign-extended to 32 bits
    function void fetch_trig(input logic [15:0] angle, output logic [31:0] s,
                             output logic [31:0] c);
      logic [31:0] a;
      logic [31:0] mag;
      logic [31:0] w;
      a   = {{16{angle[15]}}, angle};
      mag = angle[15] ? 32'd0 - a : a;
      w   = sine_cosine[12'(mag % ANGLE_STEPS)];
      s   = {{16{w[15]}}, w[15:0]};
      if (angle[15]) s = 32'd0 - s;
      c   = {{16{w[31]}}, w[31:16]};
    endfunction

    function eatrm_pkg::mat_t predict_matrix(input logic [15:0] ax,
                                             input logic [15:0] ay,
                                             input logic [15:0] az);
      logic [31:0] sx, cx, sy, cy, sz, cz, t, u;
      logic [31:0] e [eatrm_pkg::ELEM_N];
      eatrm_pkg::mat_t m;
      fetch_trig(ax, sx, cx);
      fetch_trig(ay, sy, cy);
      fetch_trig(az, sz, cz);
      t    = shr12(cz * (32'd0 - sy));
      u    = shr12(sz * (32'd0 - sy));
      e[0] = shr12(cz * cy);
      e[1] = shr12(32'd0 - sz * cy);
      e[2] = sy;
      e[3] = shr12(sz * cx) - shr12(t * sx);
      e[4] = shr12(cz * cx) + shr12(u * sx);
      e[5] = shr12(32'd0 - cy * sx);
      e[6] = shr12(sz * sx) + shr12(t * cx);
      e[7] = shr12(cz * sx) - shr12(u * cx);
      e[8] = shr12(cy * cx);
      for (int k = 0; k < eatrm_pkg::ELEM_N; k++) m[k] = e[k][15:0];
      return m;
    endfunction

    // Accepted input word: loads update the table, computes queue a matrix
    function void note_word(input eatrm_pkg::op_e op, input logic [11:0] idx,
                            input logic [31:0] word, input logic [15:0] ax,
                            input logic [15:0] ay, input logic [15:0] az);
      if (op == eatrm_pkg::OP_LOAD) begin
        sine_cosine[12'(idx % ANGLE_STEPS)] = word;
      end else begin
        pending_matrices.push_back(predict_matrix(ax, ay, az));
      end
    endfunction

    // Accepted output word against the oldest expected matrix
    function void check_matrix(input eatrm_pkg::mat_t got);
      eatrm_pkg::mat_t want;
      if (pending_matrices.size() == 0) begin
        bad_count++;
        if (shown < 10) $display("unexpected matrix, element_0 %0d", $signed(got[0]));
        shown++;
        return;
      end
      want = pending_matrices.pop_front();
      for (int k = 0; k < eatrm_pkg::ELEM_N; k++) begin
        if (want[k] !== got[k]) begin
          bad_count++;
          if (shown < 10) begin
            $display("element_%0d: expected %0d, got %0d", k, $signed(want[k]),
                     $signed(got[k]));
          end
          shown++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  eatrm_pkg::op_e op_q;
  logic [eatrm_pkg::TIDX_W-1:0]         table_index_q;
  logic [eatrm_pkg::WORD_W-1:0]         table_word_q;
  logic signed [eatrm_pkg::ANGLE_W-1:0] angle_x_q, angle_y_q, angle_z_q;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [eatrm_pkg::ELEM_W-1:0] el [eatrm_pkg::ELEM_N];

  matrix_board board = new();
  bit          send_calm;
  bit          recv_calm;
  bit          hold_on;
  bit          loaded [ANGLE_STEPS];
  int unsigned loaded_idx [$];
  int unsigned quiet_cycles;

  euler_angles_to_rotation_matrix_top #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_q),
    .table_index_i(table_index_q),
    .table_word_i (table_word_q),
    .angle_x_i    (angle_x_q),
    .angle_y_i    (angle_y_q),
    .angle_z_i    (angle_z_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .element_0_o  (el[0]),
    .element_1_o  (el[1]),
    .element_2_o  (el[2]),
    .element_3_o  (el[3]),
    .element_4_o  (el[4]),
    .element_5_o  (el[5]),
    .element_6_o  (el[6]),
    .element_7_o  (el[7]),
    .element_8_o  (el[8])
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one word after a random pause and wait until it is taken
  task automatic send_word(input eatrm_pkg::op_e op, input logic [11:0] idx,
                           input logic [31:0] word, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] az);
    int unsigned gap;
    gap = (send_calm || hold_on) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_q          <= op;
    table_index_q <= idx;
    table_word_q  <= word;
    angle_x_q     <= ax;
    angle_y_q     <= ay;
    angle_z_q     <= az;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(op, idx, word, ax, ay, az);
  endtask

  task automatic load_entry(input logic [11:0] idx, input logic [31:0] word);
    send_word(eatrm_pkg::OP_LOAD, idx, word, 16'($urandom), 16'($urandom),
              16'($urandom));
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_idx.push_back(32'(idx));
    end
  endtask

  task automatic calc(input logic [15:0] ax, input logic [15:0] ay,
                      input logic [15:0] az);
    send_word(eatrm_pkg::OP_CALC, 12'($urandom), $urandom, ax, ay, az);
  endtask

  function automatic logic [15:0] corner_half();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'h1000;
      default: return 16'hf000;
    endcase
  endfunction

  // Any angle whose magnitude maps onto a loaded entry
  function automatic logic [15:0] angle_at(input int unsigned idx);
    logic [15:0] mag;
    bit neg;
    neg = 1'($urandom_range(0, 1));
    if (idx == 0 && neg && $urandom_range(0, 7) == 0) return 16'h8000;
    mag = 16'(idx + ANGLE_STEPS * $urandom_range(0, 7));
    return neg ? 16'd0 - mag : mag;
  endfunction

  // Stimulus and end of run
  initial begin
    logic [31:0] w;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_q          = eatrm_pkg::OP_LOAD;
    table_index_q = '0;
    table_word_q  = '0;
    angle_x_q     = '0;
    angle_y_q     = '0;
    angle_z_q     = '0;
    out_stall_i   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit axes, extreme words, sine of -32768, angle -32768
    load_entry(12'd0,    32'h1000_0000);
    load_entry(12'd1024, 32'h0000_1000);
    load_entry(12'd2048, 32'h8000_8000);
    load_entry(12'd4095, 32'hffff_ffff);
    load_entry(12'd1,    32'h7fff_7fff);
    load_entry(12'd2,    32'h8000_7fff);
    calc(16'd0, 16'd0, 16'd0);
    calc(16'd1024, -16'sd1024, 16'd4095);
    calc(16'h8000, 16'h7fff, -16'sd1);
    calc(16'd2048, -16'sd2048, 16'd2048);
    calc(16'd1, -16'sd1, 16'd2);
    calc(-16'sd2, 16'h7fff, 16'h8000);
    calc(16'd4095, -16'sd4095, 16'd1024);
    load_entry(12'd0, 32'h7fff_8000);
    calc(16'd0, 16'h8000, 16'd0);

    // random: mostly angle triples over loaded entries, some table loads
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom;
        if ($urandom_range(0, 3) == 0) w[15:0] = corner_half();
        if ($urandom_range(0, 3) == 0) w[31:16] = corner_half();
        load_entry(12'($urandom), w);
      end else begin
        calc(angle_at(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]),
             angle_at(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]),
             angle_at(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]));
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending_matrices.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.bad_count == 0) begin
      $display("tb_euler_angles_to_rotation_matrix_top: done, clean");
    end else begin
      $display("tb_euler_angles_to_rotation_matrix_top: done, errors");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off to back up the block
  initial begin
    int unsigned stall;
    int unsigned taken;
    eatrm_pkg::mat_t got;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = recv_calm ? 0 : $urandom_range(0, 12);
      if (taken == HOLD_AFTER) begin
        hold_on = 1'b1;
        stall   = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(posedge clk_i);
      end
      hold_on = 1'b0;
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      for (int k = 0; k < eatrm_pkg::ELEM_N; k++) got[k] = el[k];
      board.check_matrix(got);
      taken++;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_euler_angles_to_rotation_matrix_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
